// ===== hw/rtl/rvx_pkg.sv =====
// Shared constants, status codes and request types of the RV32I executor.
`timescale 1ns / 1ps
`default_nettype none
package rvx_pkg;

	// Words in the unified memory; a power of two between 1024 and 1048576.
	localparam int unsigned MEM_WORDS = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
	localparam int unsigned BYTE_AW   = MEM_AW + 2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_HALTED  = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;
	localparam logic [1:0] ST_MISALIGN = 2'd3;

	localparam logic       REQ_LOAD = 1'b0;
	localparam logic       REQ_STEP = 1'b1;

	localparam logic [4:0] REG_A0 = 5'd10;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [31:0]       wdata;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  waddr;
		logic [31:0] wdata;
		logic [4:0]  raddr_a;
		logic [4:0]  raddr_b;
	} rf_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rv32i_instruction_executor_top.sv =====
// Top level of the RV32I executor: sequencer, execute logic and result register.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block first clears the unified memory, one word per cycle, over all
// MEM_WORDS words; no beat is accepted during that pass. A load beat writes one word and
// goes straight to the done state. A step beat fetches the word at the PC in the
// acceptance cycle, reads the register file in the next, then executes and presents its
// result through the output register. Loads and stores always read the two memory words
// that an unaligned access may span, through the single read port of the memory, and
// stores write both back through the single write port, so a load also passes through
// S_MR1 and S_MR2 and a store through S_MW1 as well. A step beat on a halted core goes
// straight to the done state without executing. One beat is handled at a time; a finished
// result waits in the output register while the next beat is accepted.
module rv32i_instruction_executor_top
	import rvx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [15:0] load_addr,
	input  wire logic [31:0] load_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      next_pc,
	output logic [7:0]       exit_code,
	output logic             reg_written,
	output logic [4:0]       reg_index,
	output logic [31:0]      reg_value
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_EXEC  = 4'd3;
	localparam logic [3:0] S_MR1   = 4'd4;
	localparam logic [3:0] S_MR2   = 4'd5;
	localparam logic [3:0] S_MW1   = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);

	logic [3:0]         state_q;
	logic [MEM_AW-1:0]  clr_q;
	logic [31:0]        pc_q;
	logic               halted_q;
	logic [7:0]         exit_q;
	logic [31:0]        ir_q;
	logic [BYTE_AW-1:0] addr_q;
	logic [31:0]        sdata_q;
	logic [31:0]        d0_q;
	logic [31:0]        hi_q;
	logic               is_store_q;
	logic [1:0]         res_status_q;
	logic [7:0]         res_exit_q;
	logic               res_wr_q;
	logic [4:0]         res_idx_q;
	logic [31:0]        res_val_q;
	logic               out_valid_q;

	mem_req_t    mreq;
	rf_req_t     rreq;
	logic [31:0] mdata;
	logic [31:0] ra;
	logic [31:0] rb;

	rvx_umem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (mdata)
	);

	rvx_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rreq),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	logic accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Execute-stage decode, following the class bits of the opcode only.
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic        hi_sub;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, alu_y, alu_r;
	logic [1:0]  x_status;
	logic [31:0] x_nx;
	logic        x_we;
	logic [31:0] x_val;
	logic        x_halt;
	logic        x_mem;
	logic        x_store;
	logic        take;

	assign f3     = ir_q[14:12];
	assign rd     = ir_q[11:7];
	assign hi_sub = (ir_q[31:30] == 2'b01);
	assign imm_i  = {{20{ir_q[31]}}, ir_q[31:20]};
	assign imm_s  = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
	assign imm_b  = {{20{ir_q[31]}}, ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
	assign imm_j  = {{12{ir_q[31]}}, ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};
	assign pc4    = pc_q + 32'd4;
	assign alu_y  = ir_q[5] ? rb : imm_i;

	always_comb begin
		unique case (f3)
			3'd0: alu_r = (ir_q[5] && hi_sub) ? ra - alu_y : ra + alu_y;
			3'd1: alu_r = ra << alu_y[4:0];
			3'd2: alu_r = {31'd0, $signed(ra) < $signed(alu_y)};
			3'd3: alu_r = {31'd0, ra < alu_y};
			3'd4: alu_r = ra ^ alu_y;
			3'd5: alu_r = hi_sub ? 32'($signed(ra) >>> alu_y[4:0]) : ra >> alu_y[4:0];
			3'd6: alu_r = ra | alu_y;
			default: alu_r = ra & alu_y;
		endcase
	end

	always_comb begin
		unique case (f3)
			3'd0: take = (ra == rb);
			3'd1: take = (ra != rb);
			3'd4: take = $signed(ra) < $signed(rb);
			3'd5: take = $signed(ra) >= $signed(rb);
			3'd6: take = ra < rb;
			3'd7: take = ra >= rb;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		x_status = ST_OK;
		x_nx     = pc4;
		x_we     = 1'b0;
		x_val    = 32'd0;
		x_halt   = 1'b0;
		x_mem    = 1'b0;
		x_store  = 1'b0;
		priority if (ir_q[1:0] != 2'b11) begin
			x_status = ST_ILLEGAL;
		end else if (ir_q[2]) begin
			if (ir_q[3]) begin
				x_we  = 1'b1;
				x_val = pc4;
				x_nx  = pc_q + imm_j;
			end else if (ir_q[4]) begin
				x_we  = 1'b1;
				x_val = ir_q[5] ? {ir_q[31:12], 12'd0} : pc_q + {ir_q[31:12], 12'd0};
			end else begin
				x_we  = 1'b1;
				x_val = pc4;
				x_nx  = (ra + imm_i) & ~32'd1;
			end
		end else if (ir_q[3]) begin
			x_status = ST_ILLEGAL;
		end else if (ir_q[4]) begin
			if (ir_q[6]) begin
				x_status = ST_ILLEGAL;
			end else if (!ir_q[5] && f3 == 3'd0 && rd == REG_A0 && imm_i == 32'hFF) begin
				x_halt   = 1'b1;
				x_status = ST_HALTED;
				x_nx     = pc_q;
			end else begin
				x_we  = 1'b1;
				x_val = alu_r;
			end
		end else if (ir_q[5]) begin
			if (ir_q[6]) begin
				if (f3 == 3'd2 || f3 == 3'd3) begin
					x_status = ST_ILLEGAL;
				end else if (take) begin
					x_nx = pc_q + imm_b;
					if (imm_b[1:0] != 2'b00) begin
						x_status = ST_MISALIGN;
					end
				end
			end else if (f3 > 3'd2) begin
				x_status = ST_ILLEGAL;
			end else begin
				x_mem   = 1'b1;
				x_store = 1'b1;
			end
		end else if (ir_q[6]) begin
			x_status = ST_ILLEGAL;
		end else if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
			x_status = ST_ILLEGAL;
		end else begin
			x_mem = 1'b1;
		end
		if (x_status == ST_ILLEGAL) begin
			x_nx = pc_q;
			x_we = 1'b0;
		end
	end

	// Byte-window logic over the two words an access may span.
	logic [1:0]  off;
	logic [5:0]  sh;
	logic [63:0] win;
	logic [31:0] ld_val;
	logic [63:0] st_data;
	logic [7:0]  st_mask;
	logic [3:0]  size_mask;
	logic [63:0] merged;

	assign off = addr_q[1:0];
	assign sh  = {1'b0, off, 3'b000};
	assign win = {mdata, d0_q} >> sh;

	always_comb begin
		unique case (f3)
			3'd0: ld_val = {{24{win[7]}}, win[7:0]};
			3'd1: ld_val = {{16{win[15]}}, win[15:0]};
			3'd4: ld_val = {24'd0, win[7:0]};
			3'd5: ld_val = {16'd0, win[15:0]};
			default: ld_val = win[31:0];
		endcase
	end

	always_comb begin
		unique case (f3[1:0])
			2'd0: size_mask = 4'b0001;
			2'd1: size_mask = 4'b0011;
			default: size_mask = 4'b1111;
		endcase
	end

	assign st_data = {32'd0, sdata_q} << sh;
	assign st_mask = {4'd0, size_mask} << off;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			merged[i*8 +: 8] = st_mask[i] ? st_data[i*8 +: 8]
				: (i < 4 ? d0_q[(i%4)*8 +: 8] : mdata[(i%4)*8 +: 8]);
		end
	end

	// Memory port selection.
	logic [MEM_AW-1:0] w0, w1, ld_w, ex_w0;
	logic [31:0]       ex_addr;
	assign w0      = addr_q[BYTE_AW-1:2];
	assign w1      = w0 + MEM_AW'(1);
	assign ld_w    = MEM_AW'({16'd0, load_addr});
	assign ex_addr = ra + (x_store ? imm_s : imm_i);
	assign ex_w0   = ex_addr[BYTE_AW-1:2];

	always_comb begin
		mreq.we    = 1'b0;
		mreq.waddr = w0;
		mreq.wdata = merged[31:0];
		mreq.raddr = pc_q[BYTE_AW-1:2];
		unique case (state_q)
			S_CLEAR: begin
				mreq.we    = 1'b1;
				mreq.waddr = clr_q;
				mreq.wdata = 32'd0;
			end
			S_IDLE: begin
				mreq.we    = accept && (req_type == REQ_LOAD);
				mreq.waddr = ld_w;
				mreq.wdata = load_data;
			end
			S_EXEC: mreq.raddr = ex_w0;
			S_MR1:  mreq.raddr = w1;
			S_MR2:  mreq.we    = is_store_q;
			S_MW1: begin
				mreq.we    = 1'b1;
				mreq.waddr = w1;
				mreq.wdata = hi_q;
			end
			default: ;
		endcase
	end

	// Register-file port selection. Port B reads a0 for the immediate ALU class so that
	// a halt can report it.
	always_comb begin
		rreq.raddr_a = mdata[19:15];
		rreq.raddr_b = (mdata[4] && !mdata[5]) ? REG_A0 : mdata[24:20];
		rreq.we      = 1'b0;
		rreq.waddr   = rd;
		rreq.wdata   = x_val;
		if (state_q == S_EXEC) begin
			rreq.we = x_we && !x_mem && (rd != 5'd0);
		end else if (state_q == S_MR2) begin
			rreq.we    = !is_store_q && (rd != 5'd0);
			rreq.wdata = ld_val;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pc_q        <= 32'd0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result beat replaces the one leaving; otherwise a taken beat empties it.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (req_type == REQ_STEP && !halted_q) ? S_DEC : S_DONE;
					end
				end
				S_DEC:  state_q <= S_EXEC;
				S_EXEC: begin
					if (x_mem) begin
						state_q <= S_MR1;
					end else begin
						state_q <= S_DONE;
						pc_q    <= x_nx;
						if (x_halt) begin
							halted_q <= 1'b1;
						end
					end
				end
				S_MR1:  state_q <= S_MR2;
				S_MR2: begin
					pc_q    <= pc_q + 32'd4;
					state_q <= is_store_q ? S_MW1 : S_DONE;
				end
				S_MW1:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_status_q <= halted_q ? ST_HALTED : ST_OK;
				res_exit_q   <= halted_q ? exit_q : 8'd0;
				res_wr_q     <= 1'b0;
				res_idx_q    <= 5'd0;
				res_val_q    <= 32'd0;
			end
			S_DEC: ir_q <= mdata;
			S_EXEC: begin
				addr_q       <= ex_addr[BYTE_AW-1:0];
				sdata_q      <= rb;
				is_store_q   <= x_store;
				res_status_q <= x_status;
				res_exit_q   <= x_halt ? rb[7:0] : 8'd0;
				if (x_halt) begin
					exit_q <= rb[7:0];
				end
				res_wr_q  <= x_we && !x_mem && (rd != 5'd0);
				res_idx_q <= (x_we && !x_mem && rd != 5'd0) ? rd : 5'd0;
				res_val_q <= (x_we && !x_mem && rd != 5'd0) ? x_val : 32'd0;
			end
			S_MR1: d0_q <= mdata;
			S_MR2: begin
				hi_q <= merged[63:32];
				if (!is_store_q && rd != 5'd0) begin
					res_wr_q  <= 1'b1;
					res_idx_q <= rd;
					res_val_q <= ld_val;
				end
			end
			S_DONE: begin
				if (out_free) begin
					status      <= res_status_q;
					next_pc     <= pc_q;
					exit_code   <= res_exit_q;
					reg_written <= res_wr_q;
					reg_index   <= res_idx_q;
					reg_value   <= res_val_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rvx_umem.sv =====
// Unified instruction and data memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rvx_umem
	import rvx_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output logic [31:0]   rdata
);

	logic [31:0] mem [MEM_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rvx_regfile.sv =====
// Register file: two registered read ports, one write port, valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none
module rvx_regfile
	import rvx_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire rf_req_t req,
	output logic [31:0]  rdata_a,
	output logic [31:0]  rdata_b
);

	logic [31:0] regs [32];
	logic [31:0] valid_q;
	logic [31:0] raw_a_q;
	logic [31:0] raw_b_q;
	logic        ok_a_q;
	logic        ok_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ok_a_q  <= 1'b0;
			ok_b_q  <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			// A register never written, and x0, read as zero.
			ok_a_q <= valid_q[req.raddr_a] && (req.raddr_a != 5'd0);
			ok_b_q <= valid_q[req.raddr_b] && (req.raddr_b != 5'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			regs[req.waddr] <= req.wdata;
		end
		raw_a_q <= regs[req.raddr_a];
		raw_b_q <= regs[req.raddr_b];
	end

	assign rdata_a = ok_a_q ? raw_a_q : 32'd0;
	assign rdata_b = ok_b_q ? raw_b_q : 32'd0;

endmodule
`default_nettype wire
